>>> rtl/tcw_pkg.sv
// shared constants and types for the text console writer
package tcw_pkg;

  localparam int NUM_COLS_DEF  = 80;
  localparam int NUM_ROWS_DEF  = 25;
  localparam int TAB_WIDTH_DEF = 8;

  localparam logic [7:0] ATTR_RESET = 8'h1F;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

endpackage

>>> rtl/tcw_ram.sv
// generic single write port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/text_console_writer_core.sv
// text console writer: cursor sequencer around one screen memory
// most commands: word registered, run in S_EXEC, result registered; new word only in S_IDLE
// tab: stop stepped from 0 in S_TAB, one stop step per cycle on the shared counter
// scroll: rows copied one row up in S_COPY, then blank last row in S_FILL, one cell per cycle
// clear: all cells blanked in S_FILL; one command at a time, input stalls while busy
// reset: synchronous, cursor to home, attribute to 0x1f, screen content undefined until cleared
module text_console_writer_core #(
  parameter int NUM_COLS  = tcw_pkg::NUM_COLS_DEF,
  parameter int NUM_ROWS  = tcw_pkg::NUM_ROWS_DEF,
  parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], target_row[12:8], target_col[19:13]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // cursor_row[4:0], cursor_col[11:5], scrolled[12]
  // attribute register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // geometry derived from the parameters
  localparam int CELL_COUNT = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(NUM_ROWS);
  localparam int COL_W      = $clog2(NUM_COLS);
  // candidate column may overshoot the last column by up to one tab width
  localparam int CC_W       = $clog2(NUM_COLS + TAB_WIDTH + 1);
  localparam int IDX_MAX    = (CELL_COUNT > NUM_COLS + TAB_WIDTH) ?
                              CELL_COUNT : NUM_COLS + TAB_WIDTH;
  localparam int IDX_W      = $clog2(IDX_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TAB,
    S_COPY,
    S_FILL,
    S_OUT
  } state_t;

  // cell index of a row/column pair
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(32'(r) * 32'(NUM_COLS) + 32'(c));
  endfunction

  state_t              state, state_next;
  tcw_pkg::cmd_t       cmd;
  logic [7:0]          ch;
  logic [4:0]          trow;
  logic [6:0]          tcol;
  logic [7:0]          attr;
  logic [ROW_W-1:0]    cur_row, cur_row_next;
  logic [COL_W-1:0]    cur_col, cur_col_next;
  logic                scr, scr_next;
  // one shared counter: tab stop search, copy and fill sweeps
  logic [IDX_W-1:0]    idx, idx_next;
  logic                cp_vld, cp_vld_next;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_wa;
  logic [15:0]         ram_wd;
  logic [15:0]         ram_rd;

  // advance handling: candidate column, row step, then wrap and scroll
  logic                adv;
  logic [CC_W-1:0]     adv_col;
  logic                adv_inc_row;
  logic                wrap;
  logic [ROW_W:0]      row_plus;
  logic                need_scroll;

  logic                fin;
  logic                slot_free;
  logic                out_load;
  logic [COL_W-1:0]    bs_col;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !m_tvalid || m_tready;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (ram_rd)
  );

  assign wrap        = adv_col >= CC_W'(NUM_COLS);
  assign row_plus    = (ROW_W+1)'(cur_row) + (ROW_W+1)'(adv_inc_row || wrap);
  assign need_scroll = row_plus >= (ROW_W+1)'(NUM_ROWS);
  assign bs_col      = (cur_col != '0) ? COL_W'(cur_col - 1'b1) : '0;

  always_comb begin
    state_next   = state;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    scr_next     = scr;
    idx_next     = idx;
    cp_vld_next  = cp_vld;
    ram_we       = 1'b0;
    ram_wa       = idx[ADDR_W-1:0];
    ram_wd       = {attr, tcw_pkg::CH_SPACE};
    adv          = 1'b0;
    adv_col      = CC_W'(cur_col);
    adv_inc_row  = 1'b0;
    fin          = 1'b0;
    out_load     = 1'b0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        scr_next = 1'b0;
        case (cmd)
          tcw_pkg::CMD_PUT: begin
            if (ch == tcw_pkg::CH_BS) begin
              // backspace at column 0 stays there and blanks that cell
              cur_col_next = bs_col;
              ram_we       = 1'b1;
              ram_wa       = cell_addr(cur_row, bs_col);
              fin          = 1'b1;
            end else if (ch == tcw_pkg::CH_TAB) begin
              idx_next   = '0;
              state_next = S_TAB;
            end else if (ch == tcw_pkg::CH_CR) begin
              cur_col_next = '0;
              fin          = 1'b1;
            end else if (ch == tcw_pkg::CH_LF) begin
              adv         = 1'b1;
              adv_col     = '0;
              adv_inc_row = 1'b1;
            end else if (ch >= tcw_pkg::CH_SPACE) begin
              ram_we  = 1'b1;
              ram_wa  = cell_addr(cur_row, cur_col);
              ram_wd  = {attr, ch};
              adv     = 1'b1;
              adv_col = CC_W'(cur_col) + CC_W'(1);
            end else begin
              // other control codes are ignored
              fin = 1'b1;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            cur_row_next = '0;
            cur_col_next = '0;
            idx_next     = '0;
            state_next   = S_FILL;
          end
          tcw_pkg::CMD_SET: begin
            // out of range targets saturate to the last row / column
            cur_row_next = (32'(trow) < NUM_ROWS) ? ROW_W'(trow) : ROW_W'(NUM_ROWS - 1);
            cur_col_next = (32'(tcol) < NUM_COLS) ? COL_W'(tcol) : COL_W'(NUM_COLS - 1);
            fin          = 1'b1;
          end
          tcw_pkg::CMD_WRITE: begin
            // out of range writes are dropped
            if (32'(trow) < NUM_ROWS && 32'(tcol) < NUM_COLS) begin
              ram_we = 1'b1;
              ram_wa = cell_addr(ROW_W'(trow), COL_W'(tcol));
              ram_wd = {attr, ch};
            end
            fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_TAB: begin
        // step the stop by one tab width until it passes the cursor
        if (idx <= IDX_W'(cur_col)) begin
          idx_next = idx + IDX_W'(TAB_WIDTH);
        end else begin
          adv     = 1'b1;
          adv_col = CC_W'(idx);
        end
      end

      S_COPY: begin
        // read cell idx, write it one row up in the next cycle
        if (idx < IDX_W'(CELL_COUNT)) begin
          idx_next    = idx + IDX_W'(1);
          cp_vld_next = 1'b1;
        end else begin
          cp_vld_next = 1'b0;
        end
        if (cp_vld) begin
          ram_we = 1'b1;
          ram_wa = ADDR_W'(idx - IDX_W'(NUM_COLS + 1));
          ram_wd = ram_rd;
        end
        if (idx == IDX_W'(CELL_COUNT) && !cp_vld) begin
          idx_next   = IDX_W'(CELL_COUNT - NUM_COLS);
          state_next = S_FILL;
        end
      end

      S_FILL: begin
        ram_we   = 1'b1;
        idx_next = idx + IDX_W'(1);
        if (idx == IDX_W'(CELL_COUNT - 1)) begin
          fin = 1'b1;
        end
      end

      S_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // wrap to the next row and scroll past the last row
    if (adv) begin
      if (need_scroll) begin
        cur_row_next = ROW_W'(NUM_ROWS - 1);
        cur_col_next = '0;
        scr_next     = 1'b1;
        idx_next     = IDX_W'(NUM_COLS);
        cp_vld_next  = 1'b0;
        state_next   = S_COPY;
      end else begin
        cur_row_next = row_plus[ROW_W-1:0];
        cur_col_next = wrap ? '0 : adv_col[COL_W-1:0];
        fin          = 1'b1;
      end
    end

    // hand the result straight to the output register when it is free
    if (fin) begin
      if (slot_free) begin
        out_load   = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur_row  <= '0;
      cur_col  <= '0;
      scr      <= 1'b0;
      idx      <= '0;
      cp_vld   <= 1'b0;
      attr     <= tcw_pkg::ATTR_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      scr     <= scr_next;
      idx     <= idx_next;
      cp_vld  <= cp_vld_next;
      if (cfg_valid) begin
        attr <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd  <= tcw_pkg::cmd_t'(s_tuser);
      ch   <= s_tdata[7:0];
      trow <= s_tdata[12:8];
      tcol <= s_tdata[19:13];
    end
    if (out_load) begin
      m_tdata <= {3'b000, scr_next, 7'(cur_col_next), 5'(cur_row_next)};
    end
  end

endmodule
